// ----- rtl/core/decimal_date_calculator_defines.svh -----
// Assertion macros for the decimal date calculator.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef DECIMAL_DATE_CALCULATOR_DEFINES_SVH
`define DECIMAL_DATE_CALCULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset only.
`define DDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define DDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DDC_ASSERT(lbl, prop, msg)
`define DDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/ddc_pkg.sv -----
// Types, constants and calendar tables of the decimal date calculator.
// Depends on nothing.
package ddc_pkg;

  localparam int unsigned DATE_W      = 27;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 7;
  localparam int unsigned DAY_W       = 7;
  localparam int unsigned QTR_W       = 3;
  localparam int unsigned DOY_W       = 9;
  localparam int unsigned WDAY_W      = 3;
  localparam int unsigned DIFF_W      = 22;
  localparam int unsigned DAYNUM_W    = 22;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam logic [DATE_W-1:0] DATE_FIRST     = 27'd17000301;
  localparam logic [DATE_W-1:0] DATE_LAST      = 27'd99991231;
  // Offsets from a date back to its year base: first of January, same and next year.
  localparam logic [DATE_W-1:0] JAN1_OFS       = 27'd101;
  localparam logic [DATE_W-1:0] NEXT_YEAR_OFS  = 27'd10101;
  localparam logic [DATE_W-1:0] NEXT_MONTH_OFS = 27'd101;
  localparam logic [YEAR_W-1:0] YEAR_FIRST     = 14'd1700;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 7'd12;

  // Reciprocal constants: x / 625 for x < 2**23, x / 100 for x < 43691,
  // x / 7 for x < 2**22; all exact without correction.
  localparam logic [25:0] DIV625_MUL   = 26'd54975582;
  localparam int unsigned DIV625_SHIFT = 35;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [22:0] DIV7_MUL     = 23'd4793491;
  localparam int unsigned DIV7_SHIFT   = 25;

  // Day number of 1700-03-01, which is a Monday.
  localparam logic [DAYNUM_W-1:0] DAYNUM_FIRST = 22'd620912;
  localparam logic [WDAY_W-1:0]   WDAY_MONDAY  = 3'd1;

  // Result word; the first field sits in the highest bits.
  typedef struct packed {
    logic [DIFF_W-1:0]  day_difference;
    logic [WDAY_W-1:0]  weekday;
    logic [DOY_W-1:0]   days_into_year;
    logic               next_overflow;
    logic [DATE_W-1:0]  next_date;
    logic               is_valid;
    logic               is_leap;
    logic [QTR_W-1:0]   quarter;
    logic [DAY_W-1:0]   day_part;
    logic [MONTH_W-1:0] month_part;
    logic [YEAR_W-1:0]  year_part;
  } res_t;

  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from 1 March to the first of the month, on a March-based year.
  function automatic logic [DOY_W-1:0] month_ofs(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] ofs;
    unique case (m)
      7'd3:    ofs = 9'd0;
      7'd4:    ofs = 9'd31;
      7'd5:    ofs = 9'd61;
      7'd6:    ofs = 9'd92;
      7'd7:    ofs = 9'd122;
      7'd8:    ofs = 9'd153;
      7'd9:    ofs = 9'd184;
      7'd10:   ofs = 9'd214;
      7'd11:   ofs = 9'd245;
      7'd12:   ofs = 9'd275;
      7'd1:    ofs = 9'd306;
      7'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // Days from 1 January to the first of the month in a common year.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] cd;
    unique case (m)
      7'd1:    cd = 9'd0;
      7'd2:    cd = 9'd31;
      7'd3:    cd = 9'd59;
      7'd4:    cd = 9'd90;
      7'd5:    cd = 9'd120;
      7'd6:    cd = 9'd151;
      7'd7:    cd = 9'd181;
      7'd8:    cd = 9'd212;
      7'd9:    cd = 9'd243;
      7'd10:   cd = 9'd273;
      7'd11:   cd = 9'd304;
      7'd12:   cd = 9'd334;
      default: cd = 9'd0;
    endcase
    return cd;
  endfunction

  function automatic logic [QTR_W-1:0] quarter_of(input logic [MONTH_W-1:0] m);
    logic [QTR_W-1:0] q;
    unique case (m)
      7'd1, 7'd2, 7'd3:    q = 3'd1;
      7'd4, 7'd5, 7'd6:    q = 3'd2;
      7'd7, 7'd8, 7'd9:    q = 3'd3;
      7'd10, 7'd11, 7'd12: q = 3'd4;
      default:             q = 3'd0;
    endcase
    return q;
  endfunction

endpackage

// ----- rtl/core/decimal_date_calculator.sv -----
// Top level of the decimal date calculator: a nine-stage pipeline.
// Depends on ddc_pkg and decimal_date_calculator_defines.svh.
//
// The block takes a word with two dates written as decimal YYYYMMDD numbers
// and returns one result word per input word: the year, month and day digit
// groups of the first date, its quarter, leap flag and validity (1700-03-01
// through 9999-12-31), the next valid date, the days since 1 January, the
// weekday (1 is Monday, 1700-03-01 is a Monday) and the absolute distance in
// days to the second date. It accepts one word every clock cycle while the
// output is not stalled. The stage count is set by the chain of reciprocal
// multipliers: the split by 10000, the split by 100, the closed-form day
// number and the reduction modulo 7 each take their own register stages.
// Each stage holds while the one after it is full and stalled, so a stall
// loses nothing and bubbles are squeezed out; input ready depends
// combinationally on output ready through the stage valid bits.
`include "decimal_date_calculator_defines.svh"

module decimal_date_calculator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [26:0] first_date, [53:27] second_date, [55:54] zero
  input  logic [ddc_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [13:0] year_part, [20:14] month_part, [27:21] day_part, [30:28] quarter,
  // [31] is_leap, [32] is_valid, [59:33] next_date, [60] next_overflow,
  // [69:61] days_into_year, [72:70] weekday, [94:73] day_difference, [95] zero
  output logic [ddc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import ddc_pkg::*;

  localparam int unsigned NS     = 9;
  localparam int unsigned LANES  = 2;
  localparam int unsigned P625_W = 49;
  localparam int unsigned P100_W = 27;
  localparam int unsigned P7_W   = 45;
  localparam int unsigned CENT_W = 8;

  // Stage valid bits and the advance chain, fed back from the output.
  logic [NS:1]   v_q;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = m_axis_tready_i;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Lane 0 carries the first date, lane 1 the second.
  logic [DATE_W-1:0]   in_date [LANES];
  // Stage 1: product for the split by 10000 (a / 10000 = (a >> 4) / 625).
  logic [DATE_W-1:0]   s1_date_q [LANES];
  logic [P625_W-1:0]   s1_prod_q [LANES];
  // Stage 2: year and the four low digits.
  logic [DATE_W-1:0]   s2_date_q [LANES];
  logic [YEAR_W-1:0]   s2_year_d [LANES], s2_year_q [LANES];
  logic [YEAR_W-1:0]   s2_rem_d  [LANES], s2_rem_q  [LANES];
  // Stage 3: products for month and century.
  logic [DATE_W-1:0]   s3_date_q [LANES];
  logic [YEAR_W-1:0]   s3_year_q [LANES], s3_rem_q [LANES];
  logic [P100_W-1:0]   s3_pm_q   [LANES], s3_pc_q  [LANES];
  // Stage 4: digit groups, century and the March-based year.
  logic [DATE_W-1:0]   s4_date_q [LANES];
  logic [YEAR_W-1:0]   s4_year_q [LANES], s4_rem_q [LANES];
  logic [MONTH_W-1:0]  s4_mon_d  [LANES], s4_mon_q [LANES];
  logic [DAY_W-1:0]    s4_day_d  [LANES], s4_day_q [LANES];
  logic [CENT_W-1:0]   s4_cent_d [LANES], s4_cent_q [LANES];
  logic [6:0]          s4_ry_d   [LANES], s4_ry_q   [LANES];
  logic [YEAR_W-1:0]   s4_ay_d   [LANES], s4_ay_q   [LANES];
  logic [CENT_W-1:0]   s4_ac_d   [LANES], s4_ac_q   [LANES];
  // Stage 5: validity, partial day numbers and most result fields.
  logic                s5_leap   [LANES];
  logic [4:0]          s5_mlen   [LANES];
  logic                s5_ok_d   [LANES], s5_ok_q [LANES];
  logic [DAYNUM_W-1:0] s5_hi_d   [LANES], s5_hi_q [LANES];
  logic [DOY_W-1:0]    s5_lo_d   [LANES], s5_lo_q [LANES];
  res_t                s5_res_d, s5_res_q;
  // Stage 6: day numbers.
  logic [DAYNUM_W-1:0] s6_dn_q   [LANES];
  logic                s6_ok1_q;
  res_t                s6_res_q;
  // Stage 7: distance and offset from the first supported day.
  logic [DAYNUM_W-1:0] s7_off_d, s7_off_q;
  res_t                s7_res_d, s7_res_q;
  // Stage 8: product for the split by 7.
  logic [DAYNUM_W-1:0] s8_off_q;
  logic [P7_W-1:0]     s8_prod_q;
  res_t                s8_res_q;
  // Stage 9: output register.
  logic [19:0]         s9_wq;
  logic [WDAY_W-1:0]   s9_wr;
  res_t                s9_res_d, res_q;

  assign in_date[0] = s_axis_tdata_i[DATE_W-1:0];
  assign in_date[1] = s_axis_tdata_i[2*DATE_W-1:DATE_W];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Stage 2: the quotient is exact, the remainder follows by one subtract.
      s2_year_d[l] = YEAR_W'(s1_prod_q[l] >> DIV625_SHIFT);
      s2_rem_d[l]  = YEAR_W'(s1_date_q[l] - DATE_W'(s2_year_d[l]) * DATE_W'(10000));

      // Stage 4.
      s4_mon_d[l]  = MONTH_W'(s3_pm_q[l] >> DIV100_SHIFT);
      s4_cent_d[l] = CENT_W'(s3_pc_q[l] >> DIV100_SHIFT);
      s4_day_d[l]  = DAY_W'(s3_rem_q[l] - YEAR_W'(s4_mon_d[l]) * YEAR_W'(100));
      s4_ry_d[l]   = 7'(s3_year_q[l] - YEAR_W'(s4_cent_d[l]) * YEAR_W'(100));
      // January and February count with the previous year; its century drops
      // by one only when the year itself is a century year.
      if (s4_mon_d[l] <= MONTH_FEB) begin
        s4_ay_d[l] = s3_year_q[l] - YEAR_W'(1);
        s4_ac_d[l] = (s4_ry_d[l] == '0) ? s4_cent_d[l] - CENT_W'(1) : s4_cent_d[l];
      end else begin
        s4_ay_d[l] = s3_year_q[l];
        s4_ac_d[l] = s4_cent_d[l];
      end

      // Stage 5.
      s5_leap[l] = (s4_year_q[l][1:0] == 2'd0 && s4_ry_q[l] != '0)
                || (s4_ry_q[l] == '0 && s4_cent_q[l][1:0] == 2'd0);
      s5_mlen[l] = month_len(s4_mon_q[l], s5_leap[l]);
      s5_ok_d[l] = s4_date_q[l] >= DATE_FIRST && s4_date_q[l] <= DATE_LAST
                && s4_day_q[l] != '0 && s4_day_q[l] <= DAY_W'(s5_mlen[l]);
      s5_hi_d[l] = DAYNUM_W'(DAYNUM_W'(s4_ay_q[l]) * DAYNUM_W'(365))
                 + DAYNUM_W'(s4_ay_q[l] >> 2)
                 - DAYNUM_W'(s4_ac_q[l])
                 + DAYNUM_W'(s4_ac_q[l] >> 2);
      s5_lo_d[l] = month_ofs(s4_mon_q[l]) + DOY_W'(s4_day_q[l]) - DOY_W'(1);
    end
  end

  // Stage 5 result fields of the first date.
  always_comb begin
    s5_res_d                = '0;
    s5_res_d.year_part      = s4_year_q[0];
    s5_res_d.month_part     = s4_mon_q[0];
    s5_res_d.day_part       = s4_day_q[0];
    s5_res_d.quarter        = quarter_of(s4_mon_q[0]);
    s5_res_d.is_leap        = s5_leap[0];
    s5_res_d.is_valid       = s5_ok_d[0];
    s5_res_d.weekday        = WDAY_MONDAY;
    s5_res_d.next_overflow  = 1'b0;
    priority if (s4_date_q[0] >= DATE_LAST) begin
      s5_res_d.next_date     = '0;
      s5_res_d.next_overflow = 1'b1;
    end else if (s4_date_q[0] < DATE_FIRST) begin
      s5_res_d.next_date = DATE_FIRST;
    end else if (s4_mon_q[0] == '0) begin
      s5_res_d.next_date = s4_date_q[0] - DATE_W'(s4_rem_q[0]) + JAN1_OFS;
    end else if (s4_mon_q[0] > MONTH_DEC) begin
      s5_res_d.next_date = s4_date_q[0] - DATE_W'(s4_rem_q[0]) + NEXT_YEAR_OFS;
    end else if (s4_day_q[0] < DAY_W'(s5_mlen[0])) begin
      s5_res_d.next_date = s4_date_q[0] + DATE_W'(1);
    end else if (s4_mon_q[0] < MONTH_DEC) begin
      s5_res_d.next_date = s4_date_q[0] - DATE_W'(s4_day_q[0]) + NEXT_MONTH_OFS;
    end else begin
      s5_res_d.next_date = s4_date_q[0] - DATE_W'(s4_rem_q[0]) + NEXT_YEAR_OFS;
    end
    // In 1700 the first of January lies before the supported span.
    if (s5_ok_d[0] && s4_year_q[0] != YEAR_FIRST) begin
      s5_res_d.days_into_year = cum_days(s4_mon_q[0]) + DOY_W'(s4_day_q[0]) - DOY_W'(1)
        + DOY_W'(s5_leap[0] && s4_mon_q[0] > MONTH_FEB);
    end
  end

  // Stage 7: distance is zero unless both dates are valid.
  always_comb begin
    s7_off_d = s6_dn_q[0] - DAYNUM_FIRST;
    s7_res_d = s6_res_q;
    if (s6_res_q.is_valid && s6_ok1_q) begin
      s7_res_d.day_difference = (s6_dn_q[0] > s6_dn_q[1]) ? s6_dn_q[0] - s6_dn_q[1]
                                                        : s6_dn_q[1] - s6_dn_q[0];
    end else begin
      s7_res_d.day_difference = '0;
    end
  end

  // Stage 9: weekday from the offset modulo 7.
  always_comb begin
    s9_wq    = 20'(s8_prod_q >> DIV7_SHIFT);
    s9_wr    = WDAY_W'(s8_off_q - DAYNUM_W'(s9_wq) * DAYNUM_W'(7));
    s9_res_d = s8_res_q;
    s9_res_d.weekday = s8_res_q.is_valid ? s9_wr + WDAY_W'(1) : WDAY_MONDAY;
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (en[1]) begin
        s1_date_q[l] <= in_date[l];
        s1_prod_q[l] <= P625_W'(in_date[l][DATE_W-1:4]) * P625_W'(DIV625_MUL);
      end
      if (en[2]) begin
        s2_date_q[l] <= s1_date_q[l];
        s2_year_q[l] <= s2_year_d[l];
        s2_rem_q[l]  <= s2_rem_d[l];
      end
      if (en[3]) begin
        s3_date_q[l] <= s2_date_q[l];
        s3_year_q[l] <= s2_year_q[l];
        s3_rem_q[l]  <= s2_rem_q[l];
        s3_pm_q[l]   <= P100_W'(s2_rem_q[l]) * P100_W'(DIV100_MUL);
        s3_pc_q[l]   <= P100_W'(s2_year_q[l]) * P100_W'(DIV100_MUL);
      end
      if (en[4]) begin
        s4_date_q[l] <= s3_date_q[l];
        s4_year_q[l] <= s3_year_q[l];
        s4_rem_q[l]  <= s3_rem_q[l];
        s4_mon_q[l]  <= s4_mon_d[l];
        s4_day_q[l]  <= s4_day_d[l];
        s4_cent_q[l] <= s4_cent_d[l];
        s4_ry_q[l]   <= s4_ry_d[l];
        s4_ay_q[l]   <= s4_ay_d[l];
        s4_ac_q[l]   <= s4_ac_d[l];
      end
      if (en[5]) begin
        s5_ok_q[l] <= s5_ok_d[l];
        s5_hi_q[l] <= s5_hi_d[l];
        s5_lo_q[l] <= s5_lo_d[l];
      end
      if (en[6]) begin
        s6_dn_q[l] <= s5_hi_q[l] + DAYNUM_W'(s5_lo_q[l]);
      end
    end
    if (en[5]) begin
      s5_res_q <= s5_res_d;
    end
    if (en[6]) begin
      s6_res_q <= s5_res_q;
      s6_ok1_q <= s5_ok_q[1];
    end
    if (en[7]) begin
      s7_res_q <= s7_res_d;
      s7_off_q <= s7_off_d;
    end
    if (en[8]) begin
      s8_res_q  <= s7_res_q;
      s8_off_q  <= s7_off_q;
      s8_prod_q <= P7_W'(s7_off_q) * P7_W'(DIV7_MUL);
    end
    if (en[9]) begin
      res_q <= s9_res_d;
    end
  end

  assign m_axis_tdata_o = OUT_TDATA_W'(res_q);

  `DDC_ASSERT(a_invalid_defaults, m_axis_tvalid_o && !res_q.is_valid |-> res_q.weekday == WDAY_MONDAY && res_q.days_into_year == '0 && res_q.day_difference == '0, "invalid date with nonzero derived fields")
  `DDC_ASSERT(a_overflow_zero, m_axis_tvalid_o && res_q.next_overflow |-> res_q.next_date == '0, "overflow with nonzero next date")
  `DDC_ASSERT(a_next_in_span, m_axis_tvalid_o && !res_q.next_overflow |-> res_q.next_date >= DATE_FIRST && res_q.next_date <= DATE_LAST, "next date outside supported span")
  `DDC_ASSERT(a_valid_fields, m_axis_tvalid_o && res_q.is_valid |-> res_q.quarter != '0 && res_q.day_part != '0 && res_q.weekday != '0, "valid date with empty fields")
  `DDC_ASSERT_ALWAYS(a_ready_when_empty, !v_q[NS] |-> s_axis_tready_o, "input stalled with empty output stage")

endmodule
